// ----- rtl/bfd_pkg.sv -----
package bfd_pkg;

  localparam int unsigned DefDepth = 64;
  localparam int unsigned FuncW    = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 6;
  localparam int unsigned StatusW  = 3;

  localparam logic [ByteW-1:0] NlByte = 8'h0A;

  localparam logic [FuncW-1:0] FuncPut   = 3'd0;
  localparam logic [FuncW-1:0] FuncRead  = 3'd1;
  localparam logic [FuncW-1:0] FuncDelim = 3'd2;
  localparam logic [FuncW-1:0] FuncLine  = 3'd3;
  localparam logic [FuncW-1:0] FuncClear = 3'd4;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StFull     = 3'd1;
  localparam logic [StatusW-1:0] StEmpty    = 3'd2;
  localparam logic [StatusW-1:0] StNotFound = 3'd3;
  localparam logic [StatusW-1:0] StSmall    = 3'd4;

  typedef enum logic [2:0] {
    OP_PUT   = 3'd0,
    OP_READ  = 3'd1,
    OP_DELIM = 3'd2,
    OP_CLEAR = 3'd3,
    OP_NOP   = 3'd4
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e          op;
    logic [ByteW-1:0] data;
    logic [LenW-1:0]  cap;
    logic             line;
  } cmd_t;

endpackage

// ----- rtl/bfd_front.sv -----
module bfd_front (
  input  logic [bfd_pkg::FuncW-1:0] func_i,
  input  logic [bfd_pkg::ByteW-1:0] data_byte_i,
  input  logic [bfd_pkg::LenW-1:0]  max_len_i,
  output bfd_pkg::cmd_t             cmd_o
);
  import bfd_pkg::*;

  always_comb begin
    cmd_o.data = data_byte_i;
    cmd_o.cap  = max_len_i;
    cmd_o.line = 1'b0;
    cmd_o.op   = OP_NOP;
    unique case (func_i)
      FuncPut: begin
        cmd_o.op = OP_PUT;
      end
      FuncRead: begin
        cmd_o.op = OP_READ;
      end
      FuncDelim: begin
        cmd_o.op = OP_DELIM;
      end
      FuncLine: begin
        cmd_o.op   = OP_DELIM;
        cmd_o.data = NlByte;
        cmd_o.line = 1'b1;
      end
      FuncClear: begin
        cmd_o.op = OP_CLEAR;
      end
      default: begin
        cmd_o.op = OP_NOP;
      end
    endcase
  end

endmodule

// ----- rtl/bfd_cmd_fifo.sv -----
module bfd_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_stall_o,
  input  bfd_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output bfd_pkg::cmd_t pop_cmd_o
);
  import bfd_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  assign push_stall_o = (cnt_q == 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- rtl/bfd_back.sv -----
module bfd_back #(
  parameter int unsigned DEPTH = bfd_pkg::DefDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  bfd_pkg::cmd_t               cmd_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bfd_pkg::ByteW-1:0]   out_byte_o,
  output logic                        last_o,
  output logic [bfd_pkg::StatusW-1:0] status_o,
  output logic [bfd_pkg::LenW-1:0]    count_o,
  output logic [bfd_pkg::LenW-1:0]    fill_level_o,
  output logic [bfd_pkg::LenW-1:0]    free_space_o
);
  import bfd_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam logic [PtrW-1:0] MaxFill = PtrW'(DEPTH - 1);
  localparam logic [PtrW:0]   DepthW  = (PtrW + 1)'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_SCAN_RD   = 5'b00010,
    S_SCAN_CMP  = 5'b00100,
    S_EMIT_RD   = 5'b01000,
    S_EMIT_WAIT = 5'b10000
  } state_e;

  function automatic logic [PtrW-1:0] wrap_add(input logic [PtrW-1:0] a,
                                               input logic [PtrW-1:0] b);
    logic [PtrW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DepthW) begin
      s = s - DepthW;
    end
    return s[PtrW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [PtrW-1:0]   rp_q, rp_d;
  logic [PtrW-1:0]   wp_q, wp_d;
  logic [PtrW-1:0]   fill_q, fill_d;
  logic [PtrW-1:0]   base_q, base_d;
  logic [PtrW-1:0]   idx_q, idx_d;
  logic [PtrW-1:0]   run_q, run_d;
  logic [ByteW-1:0]  delim_q, delim_d;
  logic [LenW-1:0]   cap_q, cap_d;
  logic              line_q, line_d;

  logic [ByteW-1:0]  mem_q [DEPTH];
  logic [ByteW-1:0]  rdata_q;
  logic [PtrW-1:0]   rd_addr;
  logic              mem_we;

  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_byte_q;
  logic              out_last_q;
  logic [StatusW-1:0] out_status_q;
  logic [LenW-1:0]   out_count_q;
  logic [LenW-1:0]   out_fill_q;
  logic [LenW-1:0]   out_free_q;
  logic              out_free;

  logic              res_load;
  logic [ByteW-1:0]  res_byte;
  logic              res_last;
  logic [StatusW-1:0] res_status;
  logic [PtrW-1:0]   res_count;
  logic [PtrW-1:0]   res_fill;

  logic [PtrW:0]     idx_inc;
  logic [PtrW-1:0]   rd_len;
  logic [PtrW-1:0]   run_found;

  assign out_free = !out_valid_q || !out_stall_i;
  assign rd_addr  = wrap_add(base_q, idx_q);
  assign idx_inc  = {1'b0, idx_q} + (PtrW + 1)'(1);
  assign run_found = idx_inc[PtrW-1:0];
  assign rd_len   = ((LenW + 1)'(fill_q) < (LenW + 1)'(cmd_i.cap)) ?
                    fill_q : PtrW'(cmd_i.cap);

  always_comb begin
    state_d    = state_q;
    rp_d       = rp_q;
    wp_d       = wp_q;
    fill_d     = fill_q;
    base_d     = base_q;
    idx_d      = idx_q;
    run_d      = run_q;
    delim_d    = delim_q;
    cap_d      = cap_q;
    line_d     = line_q;
    mem_we     = 1'b0;
    cmd_pop_o  = 1'b0;
    res_load   = 1'b0;
    res_byte   = '0;
    res_last   = 1'b1;
    res_status = StOk;
    res_count  = '0;
    res_fill   = fill_q;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_PUT: begin
              res_load = 1'b1;
              if (fill_q == MaxFill) begin
                res_status = StFull;
              end else begin
                mem_we    = 1'b1;
                wp_d      = wrap_add(wp_q, PtrW'(1));
                fill_d    = fill_q + PtrW'(1);
                res_count = PtrW'(1);
                res_fill  = fill_d;
              end
            end
            OP_CLEAR: begin
              res_load = 1'b1;
              rp_d     = '0;
              wp_d     = '0;
              fill_d   = '0;
              res_fill = '0;
            end
            OP_READ, OP_DELIM: begin
              base_d  = rp_q;
              idx_d   = '0;
              delim_d = cmd_i.data;
              cap_d   = cmd_i.cap;
              line_d  = cmd_i.line;
              if (fill_q == '0) begin
                res_load   = 1'b1;
                res_status = StEmpty;
              end else if (cmd_i.op == OP_DELIM) begin
                state_d = S_SCAN_RD;
              end else if (cmd_i.cap == '0) begin
                res_load = 1'b1;
              end else begin
                line_d  = 1'b0;
                run_d   = rd_len;
                rp_d    = wrap_add(rp_q, rd_len);
                fill_d  = fill_q - rd_len;
                state_d = S_EMIT_RD;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (rdata_q == delim_q) begin
          if ((LenW + 1)'(run_found) > (LenW + 1)'(cap_q)) begin
            if (out_free) begin
              res_load   = 1'b1;
              res_status = StSmall;
              state_d    = S_IDLE;
            end
          end else begin
            run_d   = run_found;
            rp_d    = wrap_add(rp_q, run_found);
            fill_d  = fill_q - run_found;
            idx_d   = '0;
            state_d = S_EMIT_RD;
          end
        end else if (idx_inc == {1'b0, fill_q}) begin
          if (out_free) begin
            res_load   = 1'b1;
            res_status = line_q ? StOk : StNotFound;
            state_d    = S_IDLE;
          end
        end else begin
          idx_d   = run_found;
          state_d = S_SCAN_RD;
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        res_last = (idx_inc == {1'b0, run_q});
        if (out_free) begin
          res_load  = 1'b1;
          res_byte  = (line_q && res_last) ? '0 : rdata_q;
          res_count = run_q;
          if (res_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = run_found;
            state_d = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= cmd_i.data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    idx_q   <= idx_d;
    run_q   <= run_d;
    delim_q <= delim_d;
    cap_q   <= cap_d;
    line_q  <= line_d;
    if (res_load) begin
      out_byte_q   <= res_byte;
      out_last_q   <= res_last;
      out_status_q <= res_status;
      out_count_q  <= LenW'(res_count);
      out_fill_q   <= LenW'(res_fill);
      out_free_q   <= LenW'(MaxFill - res_fill);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign last_o       = out_last_q;
  assign status_o     = out_status_q;
  assign count_o      = out_count_q;
  assign fill_level_o = out_fill_q;
  assign free_space_o = out_free_q;

endmodule

// ----- rtl/byte_ring_fifo_with_delimiter_read.sv -----
// Put, clear, spare codes, zero-cap reads and requests on an empty buffer: each result
// passes the command FIFO entry, then the output register; one request per cycle is
// sustained while the output is not stalled. Each read byte goes via S_EMIT_RD, S_EMIT_WAIT
// as store reads are registered; delimiter reads scan each byte in S_SCAN_RD, S_SCAN_CMP.
// Reset clears both pointers and the fill count; the byte store itself is not cleared.
module byte_ring_fifo_with_delimiter_read #(
  parameter int unsigned DEPTH = bfd_pkg::DefDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bfd_pkg::FuncW-1:0]   func_i,
  input  logic [bfd_pkg::ByteW-1:0]   data_byte_i,
  input  logic [bfd_pkg::LenW-1:0]    max_len_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bfd_pkg::ByteW-1:0]   out_byte_o,
  output logic                        last_o,
  output logic [bfd_pkg::StatusW-1:0] status_o,
  output logic [bfd_pkg::LenW-1:0]    count_o,
  output logic [bfd_pkg::LenW-1:0]    fill_level_o,
  output logic [bfd_pkg::LenW-1:0]    free_space_o
);
  import bfd_pkg::*;

  cmd_t dec_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  bfd_front u_front (
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .max_len_i   (max_len_i),
    .cmd_o       (dec_cmd)
  );

  bfd_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_cmd_i   (dec_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_cmd_o    (q_cmd)
  );

  bfd_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (q_cmd),
    .cmd_pop_o    (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o),
    .status_o     (status_o),
    .count_o      (count_o),
    .fill_level_o (fill_level_o),
    .free_space_o (free_space_o)
  );

endmodule

// ----- bench/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bfd_pkg::*;

  localparam int unsigned Depth      = DefDepth;
  localparam int unsigned MaxHeld    = Depth - 1;
  localparam int unsigned MaxGap     = 16;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned TailCycles = 50;

  localparam logic [FuncW-1:0] FuncSpareLo = 3'd5;
  localparam logic [FuncW-1:0] FuncSpareHi = 3'd7;

  typedef struct packed {
    logic [ByteW-1:0]   value;
    logic               fin;
    logic [StatusW-1:0] status;
    logic [LenW-1:0]    count;
    logic [LenW-1:0]    fill;
    logic [LenW-1:0]    free;
  } fifo_result_t;

  class ring_fifo_tracker;
    logic [ByteW-1:0] slots [Depth];
    logic [LenW-1:0]  rd_ptr;
    logic [LenW-1:0]  wr_ptr;
    fifo_result_t     due_results [$];
    int               errors;

    function new();
      rd_ptr = '0;
      wr_ptr = '0;
      errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function logic [LenW-1:0] held();
      return wr_ptr - rd_ptr;
    endfunction

    function bit idle();
      return due_results.size() == 0;
    endfunction

    function void push(logic [ByteW-1:0] value, logic fin, logic [StatusW-1:0] status,
                       logic [LenW-1:0] count);
      fifo_result_t r;
      r.value  = value;
      r.fin    = fin;
      r.status = status;
      r.count  = count;
      r.fill   = held();
      r.free   = LenW'(MaxHeld) - held();
      due_results.push_back(r);
    endfunction

    function void take_run(logic [LenW-1:0] n, bit zero_last);
      logic [LenW-1:0]  start;
      logic [ByteW-1:0] value;
      start  = rd_ptr;
      rd_ptr = rd_ptr + n;
      for (int k = 0; k < n; k++) begin
        value = slots[start + LenW'(k)];
        if (zero_last && k == n - 1) value = '0;
        push(value, k == n - 1, StOk, n);
      end
    endfunction

    function void scan_to(logic [ByteW-1:0] delim, logic [LenW-1:0] cap, bit line);
      logic [LenW-1:0] run;
      run = '0;
      if (held() == 0) begin
        push('0, 1'b1, StEmpty, '0);
        return;
      end
      for (int i = 0; i < held(); i++) begin
        if (slots[rd_ptr + LenW'(i)] == delim) begin
          run = LenW'(i + 1);
          break;
        end
      end
      if (run == 0) push('0, 1'b1, line ? StOk : StNotFound, '0);
      else if (run > cap) push('0, 1'b1, StSmall, '0);
      else take_run(run, line);
    endfunction

    function void apply_request(logic [FuncW-1:0] func, logic [ByteW-1:0] data,
                                logic [LenW-1:0] cap);
      case (func)
        FuncPut: begin
          if (held() == LenW'(MaxHeld)) begin
            push('0, 1'b1, StFull, '0);
          end else begin
            slots[wr_ptr] = data;
            wr_ptr = wr_ptr + 1'b1;
            push('0, 1'b1, StOk, 6'd1);
          end
        end
        FuncRead: begin
          if (held() == 0) push('0, 1'b1, StEmpty, '0);
          else if (cap == 0) push('0, 1'b1, StOk, '0);
          else take_run(held() < cap ? held() : cap, 1'b0);
        end
        FuncDelim: scan_to(data, cap, 1'b0);
        FuncLine: scan_to(NlByte, cap, 1'b1);
        FuncClear: begin
          rd_ptr = '0;
          wr_ptr = '0;
          push('0, 1'b1, StOk, '0);
        end
        default: push('0, 1'b1, StOk, '0);
      endcase
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(fifo_result_t got);
      fifo_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare("out_byte", want.value, got.value);
      compare("last", want.fin, got.fin);
      compare("status", want.status, got.status);
      compare("count", want.count, got.count);
      compare("fill_level", want.fill, got.fill);
      compare("free_space", want.free, got.free);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [FuncW-1:0]     func_i;
  logic [ByteW-1:0]     data_byte_i;
  logic [LenW-1:0]      max_len_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [ByteW-1:0]     out_byte_o;
  logic                 last_o;
  logic [StatusW-1:0]   status_o;
  logic [LenW-1:0]      count_o;
  logic [LenW-1:0]      fill_level_o;
  logic [LenW-1:0]      free_space_o;

  bit idle_on;
  bit hold_request;

  ring_fifo_tracker tracker = new();

  byte_ring_fifo_with_delimiter_read #(.DEPTH(Depth)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .data_byte_i  (data_byte_i),
    .max_len_i    (max_len_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o),
    .status_o     (status_o),
    .count_o      (count_o),
    .fill_level_o (fill_level_o),
    .free_space_o (free_space_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Each call starts and ends at a falling edge; valid stays high across back-to-back requests.
  task automatic offer_request(logic [FuncW-1:0] func, logic [ByteW-1:0] data,
                               logic [LenW-1:0] cap);
    int gap;
    gap = idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    func_i      = func;
    data_byte_i = data;
    max_len_i   = cap;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    tracker.apply_request(func, data, cap);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (!tracker.idle()) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return NlByte;
      1, 2: return ByteW'(8'h30 + $urandom_range(0, 3));
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) offer_request(FuncPut, pick_byte(), LenW'($urandom_range(0, 63)));
    else if (pick < 62) offer_request(FuncRead, ByteW'($urandom_range(0, 255)),
                                      LenW'($urandom_range(0, 63)));
    else if (pick < 76) offer_request(FuncDelim, pick_byte(), LenW'($urandom_range(0, 63)));
    else if (pick < 90) offer_request(FuncLine, ByteW'($urandom_range(0, 255)),
                                      LenW'($urandom_range(0, 63)));
    else if (pick < 95) offer_request(FuncClear, ByteW'($urandom_range(0, 255)),
                                      LenW'($urandom_range(0, 63)));
    else offer_request(FuncW'($urandom_range(FuncSpareLo, FuncSpareHi)),
                       ByteW'($urandom_range(0, 255)), LenW'($urandom_range(0, 63)));
  endtask

  initial begin : receiver
    int           stall_left;
    int           hold_left;
    bit           hold_seen;
    fifo_result_t got;
    stall_left  = 0;
    hold_left   = 0;
    hold_seen   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got = '{out_byte_o, last_o, status_o, count_o, fill_level_o, free_space_o};
        tracker.check_result(got);
        stall_left = idle_on ? $urandom_range(0, MaxGap) : 0;
      end
      if (hold_request && !hold_seen) begin
        hold_left = HoldCycles;
        hold_seen = 1'b1;
      end
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = FuncPut;
    data_byte_i  = '0;
    max_len_i    = '0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    offer_request(FuncRead, 8'h00, 6'd5);
    offer_request(FuncDelim, 8'h00, 6'd63);
    offer_request(FuncLine, 8'hFF, 6'd63);
    offer_request(FuncPut, 8'h00, 6'd0);
    offer_request(FuncPut, 8'hFF, 6'd63);
    offer_request(FuncPut, NlByte, 6'd0);
    offer_request(FuncPut, 8'h41, 6'd0);
    offer_request(FuncPut, NlByte, 6'd0);
    offer_request(FuncRead, 8'h00, 6'd0);
    offer_request(FuncDelim, 8'h77, 6'd63);
    offer_request(FuncLine, 8'h00, 6'd0);
    offer_request(FuncDelim, 8'hFF, 6'd2);
    offer_request(FuncLine, 8'h00, 6'd63);
    offer_request(FuncRead, 8'h00, 6'd1);
    offer_request(FuncLine, 8'h00, 6'd63);
    offer_request(FuncPut, 8'h55, 6'd0);
    offer_request(FuncLine, 8'h00, 6'd63);
    offer_request(FuncSpareLo, 8'hFF, 6'd63);
    offer_request(3'd6, 8'h00, 6'd0);
    offer_request(FuncSpareHi, 8'hA5, 6'd21);
    offer_request(FuncPut, 8'hAA, 6'd0);
    offer_request(FuncClear, 8'h00, 6'd0);
    offer_request(FuncRead, 8'h00, 6'd63);
    settle();

    repeat (8) random_request();
    idle_on = 1'b0;
    repeat (4) random_request();
    idle_on = 1'b1;
    settle();

    // The receiver holds off once, backing up the requests; the buffer is then filled past its capacity.
    offer_request(FuncClear, 8'h00, 6'd0);
    hold_request = 1'b1;
    repeat (MaxHeld + 1) offer_request(FuncPut, pick_byte(), LenW'($urandom_range(0, 63)));
    offer_request(FuncDelim, 8'h30, 6'd63);
    offer_request(FuncLine, 8'h00, 6'd63);
    settle();
    offer_request(FuncRead, 8'h00, 6'd63);
    settle();

    repeat (6) random_request();
    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.idle()) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
